// ----- src/fuzzy_tuned_pid_controller_defines.svh -----
// Assertion helpers for the fuzzy PID block. Expect clk and rst_n in scope.
`ifndef FUZZY_TUNED_PID_CONTROLLER_DEFINES_SVH
`define FUZZY_TUNED_PID_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define FZPID_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fzpid: same-cycle check failed");

// next-cycle implication
`define FZPID_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fzpid: next-cycle check failed");

`endif

// ----- src/fzpid_pkg.sv -----
package fzpid_pkg;

    localparam int MEAS_BITS_DEF  = 12;
    localparam int ACC_BITS_DEF   = 24;
    localparam int SETPOINT_RESET = 50;
    localparam int DRIVE_MAX      = 127;
    localparam int APB_DATA_W     = 32;
    localparam int PADDR_W        = 3;
    localparam int OUT_W          = 16;

    localparam logic [0:0] REG_SETPOINT = 1'b0;

    typedef logic [4:0] grade_t;
    typedef logic [1:0] gain_t;

    localparam grade_t             GRADE_FULL = 5'd20;
    localparam logic signed [5:0]  GRADE_POS  = 6'sd20;
    localparam logic signed [5:0]  GRADE_NEG  = -6'sd20;

    localparam gain_t GAIN_LOW  = 2'd1;
    localparam gain_t GAIN_MID  = 2'd2;
    localparam gain_t GAIN_HIGH = 2'd3;

    typedef struct packed {
        grade_t neg;
        grade_t zero;
        grade_t pos;
    } fuzzy_t;

    typedef struct packed {
        grade_t low;
        grade_t mid;
        grade_t high;
    } strength_t;

    typedef struct packed {
        logic ld_meas;
        logic ld_err;
        logic ld_delta;
        logic ld_grade;
        logic ld_rule;
        logic ld_gain;
        logic ld_mul;
        logic ld_out;
    } dp_cmd_t;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_ERR   = 8'b0000_0010,
        ST_DELTA = 8'b0000_0100,
        ST_GRADE = 8'b0000_1000,
        ST_RULE  = 8'b0001_0000,
        ST_GAIN  = 8'b0010_0000,
        ST_MUL   = 8'b0100_0000,
        ST_SUM   = 8'b1000_0000
    } ctrl_state_t;

    // input already limited to -20..20
    function automatic fuzzy_t fuzzify(input logic signed [5:0] v);
        fuzzy_t            f;
        logic signed [5:0] nv;
        f  = '0;
        nv = -v;
        if (v <= GRADE_NEG)
        begin
            f.neg = GRADE_FULL;
        end
        else if (v >= GRADE_POS)
        begin
            f.pos = GRADE_FULL;
        end
        else if (v >= 6'sd0)
        begin
            f.pos  = v[4:0];
            f.zero = GRADE_FULL - v[4:0];
        end
        else
        begin
            f.neg  = nv[4:0];
            f.zero = GRADE_FULL - nv[4:0];
        end
        return f;
    endfunction

    function automatic grade_t gmin(input grade_t a, input grade_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic grade_t gmax(input grade_t a, input grade_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic strength_t rules(input fuzzy_t e, input fuzzy_t d);
        strength_t s;
        grade_t    c_nn, c_nz, c_zn, c_zz, c_zp, c_pz, c_pp;
        c_nn   = gmin(e.neg,  d.neg);
        c_nz   = gmin(e.neg,  d.zero);
        c_zn   = gmin(e.zero, d.neg);
        c_zz   = gmin(e.zero, d.zero);
        c_zp   = gmin(e.zero, d.pos);
        c_pz   = gmin(e.pos,  d.zero);
        c_pp   = gmin(e.pos,  d.pos);
        s.low  = gmax(c_nn, c_nz);
        s.high = gmax(c_pz, c_pp);
        s.mid  = gmax(gmax(c_nz, c_zn), gmax(gmax(c_zz, c_zp), c_pz));
        return s;
    endfunction

    // (s + 2m + 3l) / (s + m + l), truncated: 3 only when s and m are zero,
    // 2 when l >= s, else 1; all three zero keeps the old gain
    function automatic gain_t blend(input grade_t s, input grade_t m, input grade_t l,
                                    input gain_t old);
        gain_t g;
        if (s == '0 && m == '0 && l == '0)
            g = old;
        else if (s == '0 && m == '0)
            g = GAIN_HIGH;
        else if (l >= s)
            g = GAIN_MID;
        else
            g = GAIN_LOW;
        return g;
    endfunction

endpackage

// ----- src/fuzzy_tuned_pid_controller.sv -----
// Fuzzy-tuned PID controller. Each accepted measurement request runs through an
// eight-state sequencer (error, change in error and integrator, fuzzy grades,
// rule strengths, gain update, gain products, clamped sum); m_tvalid rises when
// the clamped sum is registered, and the next request is taken only once the
// sequencer is back in idle, which it holds off while a finished result is not
// taken. The setpoint register lies at APB addresses 0 to 3 (paddr bit 2 clear)
// and resets to 50; the integrator, previous error and gains reset to zero.
`include "fuzzy_tuned_pid_controller_defines.svh"

module fuzzy_tuned_pid_controller
#(
    parameter int MEAS_BITS = fzpid_pkg::MEAS_BITS_DEF,
    parameter int ACC_BITS  = fzpid_pkg::ACC_BITS_DEF,
    localparam int IN_W     = ((MEAS_BITS + 7) / 8) * 8
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [IN_W-1:0]                  s_tdata,  // measurement
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fzpid_pkg::OUT_W-1:0]      m_tdata,  // drive, p_gain, i_gain, d_gain
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fzpid_pkg::PADDR_W-1:0]    paddr,
    input  logic [fzpid_pkg::APB_DATA_W-1:0] pwdata,
    output logic [fzpid_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);
    import fzpid_pkg::*;

    dp_cmd_t              cmd;
    logic                 cfg_we;
    logic [MEAS_BITS-1:0] setpoint;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready
                    && (paddr[PADDR_W-1] == REG_SETPOINT);
    assign prdata = (paddr[PADDR_W-1] == REG_SETPOINT) ? APB_DATA_W'(setpoint) : '0;

    fzpid_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    fzpid_dp
    #(
        .MEAS_BITS (MEAS_BITS),
        .ACC_BITS  (ACC_BITS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_we),
        .cfg_wdata   (pwdata[MEAS_BITS-1:0]),
        .measurement (s_tdata[MEAS_BITS-1:0]),
        .setpoint    (setpoint),
        .result      (m_tdata)
    );

    `FZPID_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready)
    `FZPID_ASSERT_NOW(a_out_slot_free, cmd.ld_out, !m_tvalid || m_tready)
    `FZPID_ASSERT_NOW(a_single_step, 1'b1, $onehot0(cmd))

endmodule

// ----- src/fzpid_ctrl.sv -----
module fzpid_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output fzpid_pkg::dp_cmd_t cmd
);
    import fzpid_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.ld_meas = s_tvalid;
                if (s_tvalid)
                    state_next = ST_ERR;
            end
            ST_ERR:
            begin
                cmd.ld_err = 1'b1;
                state_next = ST_DELTA;
            end
            ST_DELTA:
            begin
                cmd.ld_delta = 1'b1;
                state_next   = ST_GRADE;
            end
            ST_GRADE:
            begin
                cmd.ld_grade = 1'b1;
                state_next   = ST_RULE;
            end
            ST_RULE:
            begin
                cmd.ld_rule = 1'b1;
                state_next  = ST_GAIN;
            end
            ST_GAIN:
            begin
                cmd.ld_gain = 1'b1;
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.ld_mul = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.ld_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.ld_out)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

// ----- src/fzpid_dp.sv -----
module fzpid_dp
#(
    parameter int MEAS_BITS = fzpid_pkg::MEAS_BITS_DEF,
    parameter int ACC_BITS  = fzpid_pkg::ACC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  fzpid_pkg::dp_cmd_t          cmd,
    input  logic                        cfg_we,
    input  logic [MEAS_BITS-1:0]        cfg_wdata,
    input  logic [MEAS_BITS-1:0]        measurement,
    output logic [MEAS_BITS-1:0]        setpoint,
    output logic [fzpid_pkg::OUT_W-1:0] result
);
    import fzpid_pkg::*;

    localparam int ERR_W = MEAS_BITS + 1;
    localparam int DLT_W = MEAS_BITS + 2;
    localparam int INT_W = ((ACC_BITS > ERR_W) ? ACC_BITS : ERR_W) + 1;
    localparam int SUM_W = ((ACC_BITS > DLT_W) ? ACC_BITS : DLT_W) + 4;

    localparam logic signed [ACC_BITS-1:0] ACC_HI = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_LO = -ACC_HI;
    localparam logic signed [INT_W-1:0]    INT_HI = INT_W'(ACC_HI);
    localparam logic signed [INT_W-1:0]    INT_LO = INT_W'(ACC_LO);
    localparam logic signed [SUM_W-1:0]    SUM_MAX = SUM_W'(DRIVE_MAX);

    // architectural state
    logic        [MEAS_BITS-1:0] setpoint_reg;
    logic signed [ERR_W-1:0]     prev_err_reg;
    logic signed [ACC_BITS-1:0]  integ_reg;
    gain_t                       gain_p_reg, gain_i_reg, gain_d_reg;

    // working registers
    logic        [MEAS_BITS-1:0] meas_reg;
    logic signed [ERR_W-1:0]     err_reg;
    logic signed [DLT_W-1:0]     dlt_reg;
    fuzzy_t                      fe_reg, fd_reg;
    strength_t                   str_reg;
    logic signed [SUM_W-1:0]     prod_p_reg, prod_i_reg, prod_d_reg;
    logic        [OUT_W-1:0]     result_reg;

    logic signed [ERR_W-1:0]     err_next;
    logic signed [DLT_W-1:0]     dlt_next;
    logic signed [INT_W-1:0]     integ_sum;
    logic signed [ACC_BITS-1:0]  integ_next;
    logic signed [SUM_W-1:0]     sum_total;
    logic        [6:0]           drive;

    function automatic logic signed [5:0] limit_grade(input logic signed [DLT_W-1:0] v);
        logic signed [5:0] r;
        if (v <= DLT_W'(GRADE_NEG))
            r = GRADE_NEG;
        else if (v >= DLT_W'(GRADE_POS))
            r = GRADE_POS;
        else
            r = v[5:0];
        return r;
    endfunction

    // gain is 0..3: one shift-add
    function automatic logic signed [SUM_W-1:0] mul_gain(input logic signed [SUM_W-1:0] x,
                                                         input gain_t g);
        logic signed [SUM_W-1:0] a, b;
        a = g[0] ? x : '0;
        b = g[1] ? (x <<< 1) : '0;
        return a + b;
    endfunction

    assign err_next  = $signed({1'b0, setpoint_reg}) - $signed({1'b0, meas_reg});
    assign dlt_next  = DLT_W'(err_reg) - DLT_W'(prev_err_reg);
    assign integ_sum = INT_W'(integ_reg) + INT_W'(err_reg);

    always_comb
    begin
        if (integ_sum > INT_HI)
            integ_next = ACC_HI;
        else if (integ_sum < INT_LO)
            integ_next = ACC_LO;
        else
            integ_next = integ_sum[ACC_BITS-1:0];
    end

    assign sum_total = prod_p_reg + prod_i_reg + prod_d_reg;

    always_comb
    begin
        if (sum_total < 0)
            drive = '0;
        else if (sum_total > SUM_MAX)
            drive = 7'(DRIVE_MAX);
        else
            drive = sum_total[6:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg <= MEAS_BITS'(SETPOINT_RESET);
            prev_err_reg <= '0;
            integ_reg    <= '0;
            gain_p_reg   <= '0;
            gain_i_reg   <= '0;
            gain_d_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                setpoint_reg <= cfg_wdata;
            if (cmd.ld_delta)
            begin
                prev_err_reg <= err_reg;
                integ_reg    <= integ_next;
            end
            if (cmd.ld_gain)
            begin
                gain_p_reg <= blend(str_reg.low,  str_reg.mid, str_reg.high, gain_p_reg);
                gain_i_reg <= blend(str_reg.low,  str_reg.mid, str_reg.high, gain_i_reg);
                gain_d_reg <= blend(str_reg.high, str_reg.mid, str_reg.low,  gain_d_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_meas)
            meas_reg <= measurement;
        if (cmd.ld_err)
            err_reg <= err_next;
        if (cmd.ld_delta)
            dlt_reg <= dlt_next;
        if (cmd.ld_grade)
        begin
            fe_reg <= fuzzify(limit_grade(DLT_W'(err_reg)));
            fd_reg <= fuzzify(limit_grade(dlt_reg));
        end
        if (cmd.ld_rule)
            str_reg <= rules(fe_reg, fd_reg);
        if (cmd.ld_mul)
        begin
            prod_p_reg <= mul_gain(SUM_W'(err_reg),   gain_p_reg);
            prod_i_reg <= mul_gain(SUM_W'(integ_reg), gain_i_reg);
            prod_d_reg <= mul_gain(SUM_W'(dlt_reg),   gain_d_reg);
        end
        if (cmd.ld_out)
            result_reg <= OUT_W'({gain_d_reg, gain_i_reg, gain_p_reg, drive});
    end

    assign setpoint = setpoint_reg;
    assign result   = result_reg;

endmodule
